// File: hw/rtl/lpud_pkg.sv
// ----------------------------------------------------------------------------
// lpud_pkg
// Shared types and constants for the length-prefixed UTF-8 deframer.
// ----------------------------------------------------------------------------
package lpud_pkg;

	localparam int unsigned LEN_W            = 32;
	localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = 32'd1048576;

	localparam int unsigned STATUS_W = 3;
	typedef logic [STATUS_W-1:0] status_t;

	localparam status_t ST_OK        = 3'd0;
	localparam status_t ST_EOF       = 3'd1;
	localparam status_t ST_FRAMING   = 3'd2;
	localparam status_t ST_TOO_LARGE = 3'd3;
	localparam status_t ST_ENCODING  = 3'd4;

	localparam logic ACT_BYTE = 1'b0;
	localparam logic ACT_EOS  = 1'b1;

	typedef struct packed {
		logic       has_byte;
		logic [7:0] payload_byte;
		logic       last;
		status_t    status;
	} result_t;

endpackage

// File: hw/rtl/lpud_core.sv
// ----------------------------------------------------------------------------
// lpud_core
// Frame state and per-byte update: prefix gathering, length checks,
// payload countdown and structural UTF-8 tracking.
// ----------------------------------------------------------------------------
module lpud_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic                   action,
	input  logic [7:0]             data,
	input  logic [lpud_pkg::LEN_W-1:0] max_length,
	output logic                   res_valid,
	output lpud_pkg::result_t      res
);
	import lpud_pkg::*;

	logic             in_payload_q;
	logic [1:0]       prefix_index_q;
	logic [LEN_W-1:0] length_accum_q;
	logic [LEN_W-1:0] bytes_left_q;
	logic [1:0]       pending_q;
	logic             enc_err_q;

	logic             in_payload_d;
	logic [1:0]       prefix_index_d;
	logic [LEN_W-1:0] length_accum_d;
	logic [LEN_W-1:0] bytes_left_d;
	logic [1:0]       pending_d;
	logic             enc_err_d;

	logic [LEN_W-1:0] accum_new;
	logic [LEN_W-1:0] left_dec;
	logic [1:0]       pend_u;
	logic             err_u;

	assign accum_new = length_accum_q | ({24'd0, data} << {prefix_index_q, 3'b000});
	assign left_dec  = bytes_left_q - LEN_W'(1);

	// structural UTF-8 step
	always_comb begin
		pend_u = pending_q;
		err_u  = enc_err_q;
		if (pending_q != 2'd0) begin
			if (data[7:6] != 2'b10) begin
				err_u  = 1'b1;
				pend_u = 2'd0;
			end else begin
				pend_u = pending_q - 2'd1;
			end
		end else if (data[7]) begin
			if (data[7:5] == 3'b110)
				pend_u = 2'd1;
			else if (data[7:4] == 4'b1110)
				pend_u = 2'd2;
			else if (data[7:3] == 5'b11110)
				pend_u = 2'd3;
			else
				err_u = 1'b1;
		end
	end

	always_comb begin
		in_payload_d   = in_payload_q;
		prefix_index_d = prefix_index_q;
		length_accum_d = length_accum_q;
		bytes_left_d   = bytes_left_q;
		pending_d      = pending_q;
		enc_err_d      = enc_err_q;
		res_valid      = 1'b0;
		res            = '0;
		if (action == ACT_EOS) begin
			in_payload_d   = 1'b0;
			prefix_index_d = 2'd0;
			length_accum_d = '0;
			bytes_left_d   = '0;
			pending_d      = 2'd0;
			enc_err_d      = 1'b0;
			res_valid      = 1'b1;
			res.last       = 1'b1;
			res.status     = ST_EOF;
		end else if (!in_payload_q) begin
			if (prefix_index_q != 2'd3) begin
				prefix_index_d = prefix_index_q + 2'd1;
				length_accum_d = accum_new;
			end else begin
				prefix_index_d = 2'd0;
				length_accum_d = '0;
				if (accum_new == '0) begin
					res_valid  = 1'b1;
					res.last   = 1'b1;
					res.status = ST_FRAMING;
				end else if (accum_new > max_length) begin
					res_valid  = 1'b1;
					res.last   = 1'b1;
					res.status = ST_TOO_LARGE;
				end else begin
					in_payload_d = 1'b1;
					bytes_left_d = accum_new;
				end
			end
		end else begin
			res_valid        = 1'b1;
			res.has_byte     = 1'b1;
			res.payload_byte = data;
			if (left_dec == '0) begin
				res.last       = 1'b1;
				res.status     = (err_u || pend_u != 2'd0) ? ST_ENCODING : ST_OK;
				in_payload_d   = 1'b0;
				bytes_left_d   = '0;
				pending_d      = 2'd0;
				enc_err_d      = 1'b0;
			end else begin
				bytes_left_d = left_dec;
				pending_d    = pend_u;
				enc_err_d    = err_u;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_payload_q   <= 1'b0;
			prefix_index_q <= 2'd0;
			length_accum_q <= '0;
			bytes_left_q   <= '0;
			pending_q      <= 2'd0;
			enc_err_q      <= 1'b0;
		end else if (step) begin
			in_payload_q   <= in_payload_d;
			prefix_index_q <= prefix_index_d;
			length_accum_q <= length_accum_d;
			bytes_left_q   <= bytes_left_d;
			pending_q      <= pending_d;
			enc_err_q      <= enc_err_d;
		end
	end

	a_payload_count: assert property (@(posedge clk) disable iff (!arst_n)
		in_payload_q |-> bytes_left_q != '0)
		else $error("payload active with zero bytes left");

	a_prefix_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_payload_q |-> (prefix_index_q == 2'd0 && length_accum_q == '0))
		else $error("prefix state not cleared during payload");

	a_utf8_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!in_payload_q |-> (pending_q == 2'd0 && !enc_err_q && bytes_left_q == '0))
		else $error("stale UTF-8 or count state outside payload");

endmodule

// File: hw/rtl/lpud_out_reg.sv
// ----------------------------------------------------------------------------
// lpud_out_reg
// Result register on the output channel; refills in the cycle it drains.
// ----------------------------------------------------------------------------
module lpud_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  lpud_pkg::result_t load_res,
	input  logic              out_stall,
	output logic              ready,
	output logic              out_valid,
	output lpud_pkg::result_t out_res
);
	import lpud_pkg::*;

	logic    valid_s2;
	result_t res_s2;

	assign ready     = !valid_s2 || !out_stall;
	assign out_valid = valid_s2;
	assign out_res   = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (ready)
			valid_s2 <= load;
	end

	always_ff @(posedge clk) begin
		if (ready && load)
			res_s2 <= load_res;
	end

	a_cont_has_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !res_s2.last) |-> (res_s2.has_byte && res_s2.status == ST_OK))
		else $error("non-final result without a payload byte");

	a_nobyte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !res_s2.has_byte) |-> (res_s2.last && res_s2.payload_byte == 8'd0))
		else $error("byte-less result is not a final report");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> res_s2.status <= ST_ENCODING)
		else $error("status code out of range");

endmodule

// File: hw/rtl/length_prefixed_utf8_deframer.sv
// ----------------------------------------------------------------------------
// length_prefixed_utf8_deframer
// Splits a byte stream into frames carrying a 4-byte little-endian length
// prefix, forwards payload bytes and checks UTF-8 structure per frame.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall with action (0 byte, 1 end of stream)
// and data. Output channel: out_valid/out_stall with has_byte,
// payload_byte, last and status. Zero or one result per input transfer;
// prefix bytes give none unless the fourth one fails the length check.
// cfg_write/cfg_data load max_length; write it only while idle.
// Each input transfer is held in the input register, and its result in
// the result register, before it reaches the output channel.
// Throughput: one transfer per cycle while the receiver does not stall;
// the whole per-byte update is one pass between the two registers.
// Receiver stall holds the result register; the input register still drains
// items that produce no result, otherwise in_stall rises one item later.
// Reset clears all frame state and the pipeline and restores max_length to
// 1048576; the block then expects a fresh length prefix.
// ----------------------------------------------------------------------------
module length_prefixed_utf8_deframer (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_write,
	input  logic [lpud_pkg::LEN_W-1:0] cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       action,
	input  logic [7:0]                 data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       has_byte,
	output logic [7:0]                 payload_byte,
	output logic                       last,
	output lpud_pkg::status_t          status
);
	import lpud_pkg::*;

	logic [LEN_W-1:0] max_length_q;
	logic             valid_s1;
	logic             action_s1;
	logic [7:0]       data_s1;
	logic             accept;
	logic             advance;
	logic             res_valid;
	logic             out_ready;
	result_t          res;
	result_t          out_res;

	assign advance  = valid_s1 && (!res_valid || out_ready);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			max_length_q <= MAX_LENGTH_RESET;
		else if (cfg_write)
			max_length_q <= cfg_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (accept)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= action;
			data_s1   <= data;
		end
	end

	lpud_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.action     (action_s1),
		.data       (data_s1),
		.max_length (max_length_q),
		.res_valid  (res_valid),
		.res        (res)
	);

	lpud_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && res_valid),
		.load_res  (res),
		.out_stall (out_stall),
		.ready     (out_ready),
		.out_valid (out_valid),
		.out_res   (out_res)
	);

	assign has_byte     = out_res.has_byte;
	assign payload_byte = out_res.payload_byte;
	assign last         = out_res.last;
	assign status       = out_res.status;

endmodule
